FILE: rtl/flow_table_with_aging_top_macros.svh
// Assertion macros for the flow table with aging.
`ifndef FLOW_TABLE_WITH_AGING_TOP_MACROS_SVH
`define FLOW_TABLE_WITH_AGING_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define FTA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define FTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fta_pkg.sv
// Types and constants shared by the flow table with aging.
package fta_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BL_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WL_TIMEOUT = 1'b1;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CHECK  = 1'b1;

	localparam logic LIST_BLOCKED = 1'b0;
	localparam logic LIST_ALLOWED = 1'b1;

	localparam logic [31:0] KEY_MULT = 32'd59;
	localparam logic [31:0] BL_TIMEOUT_RESET = 32'd600;
	localparam logic [31:0] WL_TIMEOUT_RESET = 32'd100;

	typedef struct packed {
		logic        cmd;
		logic        list_select;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] dst_port_num;
		logic [7:0]  proto_num;
		logic [63:0] timestamp;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        insert_failed;
		logic [31:0] flow_key;
	} rsp_t;

	typedef struct packed {
		logic        vld;
		logic [31:0] key;
		logic [63:0] stamp;
	} mem_word_t;

	function automatic logic [31:0] fold_key(input req_t r);
		logic [31:0] k;
		k = 32'(r.src_addr * KEY_MULT);
		k = k ^ r.dst_addr ^ {r.dst_port_num, 16'h0000} ^ {24'h000000, r.proto_num};
		return k;
	endfunction

endpackage

FILE: rtl/fta_mem.sv
// Entry store: key, timestamp and valid flag per slot, one write and one read port.
module fta_mem import fta_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  mem_word_t       wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output mem_word_t       rdata
);

	mem_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/flow_table_with_aging_top.sv
// Top level of the flow table with aging: key fold, list scan and result register.
// An item runs from start to done through a scan of at most ENTRIES_PER_LIST slots and a finish step,
// ending the scan early on a match; the scan reads one slot of the selected list per cycle from the store.
// Throughput: the next item may start in the cycle done is high.
// Reset: timeouts load 600 and 100; a clearing pass then writes all 2*ENTRIES_PER_LIST
// slots invalid, one per cycle, with busy high; config writes are taken meanwhile.
`include "flow_table_with_aging_top_macros.svh"
module flow_table_with_aging_top import fta_pkg::*; #(
	parameter int ENTRIES_PER_LIST = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOTS = 2 * ENTRIES_PER_LIST;
	localparam int AW = $clog2(SLOTS);
	localparam int IW = (ENTRIES_PER_LIST > 1) ? $clog2(ENTRIES_PER_LIST) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES_PER_LIST - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(SLOTS - 1);
	localparam logic [AW-1:0] LIST_BASE = AW'(ENTRIES_PER_LIST);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [31:0]   bl_q;
	logic [31:0]   wl_q;
	logic          cmd_q;
	logic          sel_q;
	logic [31:0]   key_q;
	logic [63:0]   ts_q;
	logic [63:0]   time_q;
	logic [IW-1:0] scan_idx_q;
	logic          scan_on_q;
	logic          rd_valid_s1;
	logic [IW-1:0] idx_s1;
	logic          match_q;
	logic [IW-1:0] match_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	mem_word_t     mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	mem_word_t     mem_rdata;

	logic          rd_match;
	logic [63:0]   age;
	logic [63:0]   limit;
	logic          fresh;
	logic          fin_hit;
	logic          fin_failed;

	function automatic logic [AW-1:0] slot_addr(input logic sel, input logic [IW-1:0] idx);
		return (sel == LIST_ALLOWED) ? LIST_BASE + AW'(idx) : AW'(idx);
	endfunction

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign mem_re    = (state_q == ST_SCAN) && scan_on_q;
	assign mem_raddr = slot_addr(sel_q, scan_idx_q);
	assign rd_match  = mem_rdata.vld && (mem_rdata.key == key_q);

	assign age   = ts_q - time_q;
	assign limit = {32'h00000000, (sel_q == LIST_ALLOWED) ? wl_q : bl_q};
	assign fresh = (age <= limit);

	assign fin_hit    = (cmd_q == CMD_CHECK) && match_q && fresh;
	assign fin_failed = (cmd_q == CMD_INSERT) && !match_q && !free_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '{vld: 1'b0, key: key_q, stamp: ts_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_FINISH: begin
				if (cmd_q == CMD_INSERT) begin
					mem_we        = match_q || free_q;
					mem_waddr     = slot_addr(sel_q, match_q ? match_idx_q : free_idx_q);
					mem_wdata.vld = 1'b1;
				end else begin
					mem_we    = match_q && !fresh;
					mem_waddr = slot_addr(sel_q, match_idx_q);
				end
			end
			ST_IDLE, ST_SCAN: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	fta_mem #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_q <= BL_TIMEOUT_RESET;
			wl_q <= WL_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BL_TIMEOUT: bl_q <= cfg_data;
				REG_WL_TIMEOUT: wl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (state_q == ST_IDLE && start) begin
			cmd_q <= req.cmd;
			sel_q <= req.list_select;
			ts_q  <= req.timestamp;
			key_q <= fold_key(req);
		end
		if (state_q == ST_SCAN && rd_valid_s1) begin
			if (rd_match) begin
				match_idx_q <= idx_s1;
				time_q      <= mem_rdata.stamp;
			end else if (!mem_rdata.vld && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_FINISH) begin
			rsp_q <= '{hit: fin_hit, insert_failed: fin_failed, flow_key: key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_idx_q  <= '0;
			scan_on_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= mem_re;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						scan_idx_q <= '0;
						scan_on_q  <= 1'b1;
						match_q    <= 1'b0;
						free_q     <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance the read side
					if (scan_on_q) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						if (scan_idx_q == IDX_LAST) begin
							scan_on_q <= 1'b0;
						end
					end
					// resolve the slot read last cycle
					if (rd_valid_s1) begin
						if (rd_match) begin
							match_q   <= 1'b1;
							scan_on_q <= 1'b0;
							state_q   <= ST_FINISH;
						end else begin
							if (!mem_rdata.vld) begin
								free_q <= 1'b1;
							end
							if (idx_s1 == IDX_LAST) begin
								state_q <= ST_FINISH;
							end
						end
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FTA_ASSERT_SAME(a_done_idle, done, !busy, "result word issued while busy")
	`FTA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start a scan")
	`FTA_ASSERT_SAME(a_rsp_excl, done, !(rsp.hit && rsp.insert_failed),
		"hit and insert failure in one word")
	`FTA_ASSERT_SAME(a_hit_check, done && rsp.hit, cmd_q == CMD_CHECK, "hit on an insert")
	`FTA_ASSERT_SAME(a_write_phase, mem_we, state_q == ST_FINISH || state_q == ST_CLEAR,
		"store written during scan")

endmodule
